### hdl/framed_link_receiver_defines.svh
// Assertion helpers used by the checker file.
`ifndef FRAMED_LINK_RECEIVER_DEFINES_SVH
`define FRAMED_LINK_RECEIVER_DEFINES_SVH

// Checked on every clock edge once reset is released.
`define FLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FLR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/flr_pkg.sv
`default_nettype none

package flr_pkg;

  localparam int unsigned MaxPayloadDefault = 250;
  localparam int unsigned HeaderLen         = 5;
  localparam int unsigned SavedPayload      = 3;
  localparam int unsigned AddrWidth         = 5;

  localparam logic [7:0] FcData = 8'h04;
  localparam logic [7:0] FcAck  = 8'h06;

  localparam logic [7:0]  StartDelimReset = 8'd104;
  localparam logic [7:0]  EndDelimReset   = 8'd22;
  localparam logic [15:0] TimeoutReset    = 16'd100;
  localparam logic [7:0]  AckReset        = 8'd6;
  localparam logic [7:0]  NackReset       = 8'd21;

  typedef enum logic [2:0] {
    RegStartDelim = 3'd0,
    RegEndDelim   = 3'd1,
    RegTimeout    = 3'd2,
    RegAck        = 3'd3,
    RegNack       = 3'd4
  } flr_reg_e;

  typedef enum logic [1:0] {
    StatusGood    = 2'd0,
    StatusBad     = 2'd1,
    StatusTimeout = 2'd2
  } flr_status_e;

  typedef enum logic [6:0] {
    PhIdle  = 7'b0000001,
    PhLen1  = 7'b0000010,
    PhLen2  = 7'b0000100,
    PhSd2   = 7'b0001000,
    PhBody  = 7'b0010000,
    PhCheck = 7'b0100000,
    PhEnd   = 7'b1000000
  } flr_phase_e;

  typedef struct packed {
    logic [7:0]  start_delimiter;
    logic [7:0]  end_delimiter;
    logic [15:0] timeout_ticks;
    logic [7:0]  ack_value;
    logic [7:0]  nack_value;
  } flr_cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } flr_in_t;

  typedef struct packed {
    logic        frame_end;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [7:0]  dest_address;
    logic [7:0]  source_address;
    logic [7:0]  function_code;
    logic [7:0]  dest_service;
    logic [7:0]  source_service;
    logic [15:0] service_id;
    logic [31:0] packet_number;
    logic [7:0]  flow_code;
    logic [7:0]  payload_count;
  } flr_out_t;

endpackage

`default_nettype wire

### hdl/framed_link_receiver.sv
// Framed link receiver: takes one word per cycle on the input channel, either a received
// byte or a time tick, and parses delimited frames with a repeated length, a five byte
// header, payload, an 8-bit sum check and an end delimiter. Each payload byte comes out
// as its own result word; each finished or timed-out frame gives one status word with the
// header fields, held packet number and flow code. Throughput is one input word per
// cycle when the output is not stalled; an accepted word passes the input register and
// then its result the result register, and a stalled output backs up through both
// registers. Words that give no result still pass the input register. Write the
// registers over the APB port only while the block is idle.
`default_nettype none

module framed_link_receiver #(
  parameter int unsigned MaxPayload = flr_pkg::MaxPayloadDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire flr_pkg::flr_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output flr_pkg::flr_out_t                  out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [flr_pkg::AddrWidth-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  flr_pkg::flr_cfg_t cfg;
  flr_pkg::flr_in_t  in_q;
  flr_pkg::flr_out_t out_q;
  flr_pkg::flr_out_t res;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              fire;
  logic              res_valid;

  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  flr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  flr_parser #(
    .MaxPayload (MaxPayload)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

### hdl/flr_regs.sv
`default_nettype none

module flr_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [flr_pkg::AddrWidth-1:0]   paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output flr_pkg::flr_cfg_t                    cfg_o
);

  flr_pkg::flr_cfg_t cfg_q;
  flr_pkg::flr_reg_e reg_sel;
  logic              wr_en;

  assign reg_sel = flr_pkg::flr_reg_e'(paddr[flr_pkg::AddrWidth-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_delimiter <= flr_pkg::StartDelimReset;
      cfg_q.end_delimiter   <= flr_pkg::EndDelimReset;
      cfg_q.timeout_ticks   <= flr_pkg::TimeoutReset;
      cfg_q.ack_value       <= flr_pkg::AckReset;
      cfg_q.nack_value      <= flr_pkg::NackReset;
    end else if (wr_en) begin
      case (reg_sel)
        flr_pkg::RegStartDelim: cfg_q.start_delimiter <= pwdata[7:0];
        flr_pkg::RegEndDelim:   cfg_q.end_delimiter   <= pwdata[7:0];
        flr_pkg::RegTimeout:    cfg_q.timeout_ticks   <= pwdata[15:0];
        flr_pkg::RegAck:        cfg_q.ack_value       <= pwdata[7:0];
        flr_pkg::RegNack:       cfg_q.nack_value      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      flr_pkg::RegStartDelim: prdata = {24'd0, cfg_q.start_delimiter};
      flr_pkg::RegEndDelim:   prdata = {24'd0, cfg_q.end_delimiter};
      flr_pkg::RegTimeout:    prdata = {16'd0, cfg_q.timeout_ticks};
      flr_pkg::RegAck:        prdata = {24'd0, cfg_q.ack_value};
      flr_pkg::RegNack:       prdata = {24'd0, cfg_q.nack_value};
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/flr_parser.sv
`default_nettype none

module flr_parser #(
  parameter int unsigned MaxPayload = flr_pkg::MaxPayloadDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire flr_pkg::flr_in_t  item_i,
  input  wire flr_pkg::flr_cfg_t cfg_i,
  output logic                   res_valid_o,
  output flr_pkg::flr_out_t      res_o
);

  localparam logic [8:0] MaxLen  = 9'(MaxPayload + flr_pkg::HeaderLen);
  localparam logic [7:0] HdrLen  = 8'(flr_pkg::HeaderLen);
  localparam logic [7:0] SavedN  = 8'(flr_pkg::SavedPayload);

  flr_pkg::flr_phase_e phase_q, phase_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  hdr_q [flr_pkg::HeaderLen];
  logic [7:0]  hdr_d [flr_pkg::HeaderLen];
  logic [7:0]  fp_q  [flr_pkg::SavedPayload];
  logic [7:0]  fp_d  [flr_pkg::SavedPayload];
  logic [7:0]  chk_q, chk_d;
  logic [15:0] tick_q, tick_d;
  logic [31:0] pkt_q, pkt_d;
  logic [7:0]  flow_q, flow_d;

  logic [7:0]  b;
  logic [15:0] tick_inc;
  logic [7:0]  pidx;
  logic [7:0]  cnt_inc;
  logic [7:0]  pcount;
  logic        emit_end;
  logic        emit_pay;
  flr_pkg::flr_status_e st;

  assign b        = item_i.rx_byte;
  assign tick_inc = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
  assign pidx     = cnt_q - HdrLen;
  assign cnt_inc  = cnt_q + 8'd1;
  assign pcount   = (cnt_q > HdrLen) ? cnt_q - HdrLen : 8'd0;

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    hdr_d    = hdr_q;
    fp_d     = fp_q;
    chk_d    = chk_q;
    tick_d   = tick_q;
    pkt_d    = pkt_q;
    flow_d   = flow_q;
    emit_end = 1'b0;
    emit_pay = 1'b0;
    st       = flr_pkg::StatusBad;

    if (fire_i) begin
      if (item_i.mode) begin
        if (phase_q != flr_pkg::PhIdle) begin
          tick_d = tick_inc;
          if (tick_inc >= cfg_i.timeout_ticks) begin
            emit_end = 1'b1;
            st       = flr_pkg::StatusTimeout;
            phase_d  = flr_pkg::PhIdle;
          end
        end
      end else begin
        case (phase_q)
          flr_pkg::PhIdle: begin
            if (b == cfg_i.start_delimiter) begin
              len_d   = '0;
              cnt_d   = '0;
              sum_d   = '0;
              chk_d   = '0;
              tick_d  = '0;
              for (int i = 0; i < flr_pkg::HeaderLen; i++) hdr_d[i] = '0;
              for (int i = 0; i < flr_pkg::SavedPayload; i++) fp_d[i] = '0;
              phase_d = flr_pkg::PhLen1;
            end
          end
          flr_pkg::PhLen1: begin
            len_d   = b;
            phase_d = flr_pkg::PhLen2;
          end
          flr_pkg::PhLen2: begin
            if (b != len_q || len_q < HdrLen || {1'b0, len_q} > MaxLen) begin
              phase_d = flr_pkg::PhIdle;
            end else begin
              phase_d = flr_pkg::PhSd2;
            end
          end
          flr_pkg::PhSd2: begin
            if (b != cfg_i.start_delimiter) begin
              phase_d = flr_pkg::PhIdle;
            end else begin
              tick_d  = '0;
              cnt_d   = '0;
              sum_d   = '0;
              // length was range checked, so the body is never empty
              phase_d = flr_pkg::PhBody;
            end
          end
          flr_pkg::PhBody: begin
            sum_d = sum_q + b;
            if (cnt_q < HdrLen) begin
              hdr_d[cnt_q[2:0]] = b;
            end else begin
              if (pidx < SavedN) fp_d[pidx[1:0]] = b;
              emit_pay = 1'b1;
            end
            cnt_d = cnt_inc;
            if (cnt_inc >= len_q) phase_d = flr_pkg::PhCheck;
          end
          flr_pkg::PhCheck: begin
            chk_d   = b;
            phase_d = flr_pkg::PhEnd;
          end
          flr_pkg::PhEnd: begin
            if (b == cfg_i.end_delimiter && chk_q == sum_q) begin
              st = flr_pkg::StatusGood;
              if (hdr_q[2] == flr_pkg::FcData) begin
                pkt_d = {hdr_q[3], hdr_q[4], fp_q[0], fp_q[1]};
              end else if (hdr_q[2] == flr_pkg::FcAck) begin
                // nack wins when both values match
                if (hdr_q[3] == cfg_i.nack_value) begin
                  flow_d = cfg_i.nack_value;
                end else if (hdr_q[3] == cfg_i.ack_value) begin
                  flow_d = cfg_i.ack_value;
                end
                pkt_d = {hdr_q[4], fp_q[0], fp_q[1], fp_q[2]};
              end
            end
            emit_end = 1'b1;
            phase_d  = flr_pkg::PhIdle;
          end
          default: phase_d = flr_pkg::PhIdle;
        endcase
      end
    end
  end

  always_comb begin
    res_o       = '0;
    res_valid_o = emit_end || emit_pay;
    if (emit_pay) begin
      res_o.payload_byte = b;
    end else if (emit_end) begin
      res_o.frame_end      = 1'b1;
      res_o.status         = st;
      res_o.dest_address   = hdr_q[0];
      res_o.source_address = hdr_q[1];
      res_o.function_code  = hdr_q[2];
      res_o.dest_service   = hdr_q[3];
      res_o.source_service = hdr_q[4];
      res_o.service_id     = {hdr_q[3], hdr_q[4]};
      res_o.packet_number  = pkt_d;
      res_o.flow_code      = flow_d;
      res_o.payload_count  = pcount;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= flr_pkg::PhIdle;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      chk_q   <= '0;
      tick_q  <= '0;
      pkt_q   <= '0;
      flow_q  <= '0;
      for (int i = 0; i < flr_pkg::HeaderLen; i++) hdr_q[i] <= '0;
      for (int i = 0; i < flr_pkg::SavedPayload; i++) fp_q[i] <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      chk_q   <= chk_d;
      tick_q  <= tick_d;
      pkt_q   <= pkt_d;
      flow_q  <= flow_d;
      hdr_q   <= hdr_d;
      fp_q    <= fp_d;
    end
  end

endmodule

`default_nettype wire

### hdl/flr_checker.sv
`default_nettype none
`include "framed_link_receiver_defines.svh"

module flr_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire flr_pkg::flr_out_t out_data_o
);

  `FLR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result word changed while stalled")
  `FLR_ASSERT(a_pay_clean, out_valid_o && !out_data_o.frame_end |-> out_data_o.status == flr_pkg::StatusGood && out_data_o.payload_count == 8'd0 && out_data_o.packet_number == 32'd0, "payload word carries status fields")
  `FLR_ASSERT(a_status_code, out_valid_o && out_data_o.frame_end |-> out_data_o.status == flr_pkg::StatusGood || out_data_o.status == flr_pkg::StatusBad || out_data_o.status == flr_pkg::StatusTimeout, "unknown status code")
  `FLR_ASSERT(a_service_id, out_valid_o |-> out_data_o.service_id == {out_data_o.dest_service, out_data_o.source_service}, "service id does not match service bytes")
  `FLR_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind framed_link_receiver flr_checker u_flr_checker (.*);

`default_nettype wire
